@@ design/irp_pkg.sv @@
// Shared types, constants and helpers for the in-place random permutation block.
// No dependencies; every other file takes names from here by scope.
package irp_pkg;

    localparam int MAX_CARDS = 64;
    localparam int CARD_W    = $clog2(MAX_CARDS);
    localparam int CFG_W     = 7;
    localparam int WORD_W    = 32;
    localparam int DVS_W     = CARD_W + 1;
    localparam int CNT_W     = $clog2(WORD_W);

    localparam logic [CFG_W-1:0] RESET_DECK_SIZE = CFG_W'(52);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_READ,
        S_SWAP_I,
        S_SWAP_J,
        S_EMIT,
        S_EMIT_LAST
    } t_state;

    // Write side of the deck store
    typedef struct packed {
        logic              clear;
        logic              we;
        logic [CARD_W-1:0] waddr;
        logic [CARD_W-1:0] wdata;
    } t_mem_wr;

    // Highest position of a shuffle: deck size saturated to [2, MAX_CARDS], minus one
    function automatic logic [CARD_W-1:0] top_of(input logic [CFG_W-1:0] size);
        logic [CFG_W-1:0] n;
        n = size;
        if (size < CFG_W'(2)) begin
            n = CFG_W'(2);
        end
        if (size > CFG_W'(MAX_CARDS)) begin
            n = CFG_W'(MAX_CARDS);
        end
        return CARD_W'(n - CFG_W'(1));
    endfunction

endpackage

@@ design/irp_if.sv @@
// Valid/ready channel interfaces of the permutation block.
// Depends on irp_pkg for payload widths.
interface irp_word_if;
    logic                         valid;
    logic                         ready;
    logic [irp_pkg::WORD_W-1:0]   random_word;

    modport source (output valid, output random_word, input ready);
    modport sink   (input valid, input random_word, output ready);
endinterface

interface irp_card_if;
    logic                         valid;
    logic                         ready;
    logic [irp_pkg::CARD_W-1:0]   card_value;
    logic [irp_pkg::CARD_W-1:0]   position;
    logic                         last;

    modport source (output valid, output card_value, output position, output last,
                    input ready);
    modport sink   (input valid, input card_value, input position, input last,
                    output ready);
endinterface

interface irp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [irp_pkg::CFG_W-1:0]    deck_size;

    modport source (output valid, output deck_size, input ready);
    modport sink   (input valid, input deck_size, output ready);
endinterface

@@ design/in_place_random_permutation.sv @@
// Top level of the in-place random permutation (shuffle) block: sequencer,
// output register, remainder unit and deck store. Depends on irp_pkg, irp_if.sv,
// irp_rem_unit and irp_deck_mem.
//
//   channel   dir  payload                          transaction
//   i_word    in   random_word[31:0]                one swap step
//   o_card    out  card_value[5:0] position[5:0] last   one settled entry
//   i_cfg     in   deck_size[6:0]                   restart with new size
//
// With a free output, each word passes from acceptance to acceptance through
// the accepting idle state, irp_rem_unit (one step per dividend bit, then done),
// a read, two single-port writes and the hand-over to the output register.
// The step at position 1 writes nothing and hands over two results.
// Reset (synchronous, active low) sets deck size 52 and the identity deck.
// A stalled output holds the sequencer only when the output register is full.
module in_place_random_permutation (
    input  logic             i_clk,
    input  logic             i_rst_n,
    irp_word_if.sink         i_word,
    irp_card_if.source       o_card,
    irp_cfg_if.sink          i_cfg
);

    irp_pkg::t_state               r_state;
    irp_pkg::t_state               n_state;
    logic [irp_pkg::CFG_W-1:0]     r_deck_size;
    logic [irp_pkg::CARD_W-1:0]    r_top;
    logic [irp_pkg::CARD_W-1:0]    r_j;
    logic [irp_pkg::CARD_W-1:0]    r_val_a;
    logic [irp_pkg::CARD_W-1:0]    r_val_b;
    logic                          r_out_valid;
    logic [irp_pkg::CARD_W-1:0]    r_out_card;
    logic [irp_pkg::CARD_W-1:0]    r_out_pos;
    logic                          r_out_last;

    logic                          word_ready;
    logic                          cfg_ready;
    logic                          word_acc;
    logic                          cfg_acc;
    logic                          slot_free;
    logic                          is_one;
    logic                          div_start;
    logic                          rem_done;
    logic [irp_pkg::CARD_W-1:0]    rem;
    irp_pkg::t_mem_wr              mem_wr;
    logic [irp_pkg::CARD_W-1:0]    raddr_a;
    logic [irp_pkg::CARD_W-1:0]    raddr_b;
    logic [irp_pkg::CARD_W-1:0]    rdata_a;
    logic [irp_pkg::CARD_W-1:0]    rdata_b;
    logic                          out_load;
    logic [irp_pkg::CARD_W-1:0]    out_card;
    logic [irp_pkg::CARD_W-1:0]    out_pos;
    logic                          out_last;

    assign word_acc  = i_word.valid && word_ready;
    assign cfg_acc   = i_cfg.valid && cfg_ready;
    assign slot_free = !r_out_valid || o_card.ready;
    assign is_one    = (r_top == irp_pkg::CARD_W'(1));

    // The final step swaps entries 0 and 1 only: read both, write neither
    assign raddr_a = is_one ? '0 : r_top;
    assign raddr_b = is_one ? irp_pkg::CARD_W'(1) : r_j;

    irp_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_word.random_word),
        .i_divisor  ({1'b0, r_top} + irp_pkg::DVS_W'(1)),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    irp_deck_mem u_deck (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (mem_wr),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            irp_pkg::S_IDLE: begin
                if (word_acc) begin
                    n_state = irp_pkg::S_DIV;
                end
            end
            irp_pkg::S_DIV: begin
                if (rem_done) begin
                    n_state = irp_pkg::S_READ;
                end
            end
            irp_pkg::S_READ: begin
                n_state = irp_pkg::S_SWAP_I;
            end
            irp_pkg::S_SWAP_I: begin
                n_state = is_one ? irp_pkg::S_EMIT : irp_pkg::S_SWAP_J;
            end
            irp_pkg::S_SWAP_J: begin
                n_state = irp_pkg::S_EMIT;
            end
            irp_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_state = is_one ? irp_pkg::S_EMIT_LAST : irp_pkg::S_IDLE;
                end
            end
            irp_pkg::S_EMIT_LAST: begin
                if (slot_free) begin
                    n_state = irp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = irp_pkg::S_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        word_ready   = 1'b0;
        cfg_ready    = 1'b0;
        div_start    = 1'b0;
        mem_wr.clear = 1'b0;
        mem_wr.we    = 1'b0;
        mem_wr.waddr = r_top;
        mem_wr.wdata = rdata_b;
        out_load     = 1'b0;
        out_card     = r_val_b;
        out_pos      = r_top;
        out_last     = 1'b0;
        case (r_state)
            irp_pkg::S_IDLE: begin
                cfg_ready    = 1'b1;
                word_ready   = !i_cfg.valid;
                div_start    = i_word.valid && !i_cfg.valid;
                mem_wr.clear = i_cfg.valid;
            end
            irp_pkg::S_SWAP_I: begin
                mem_wr.we = !is_one;
            end
            irp_pkg::S_SWAP_J: begin
                mem_wr.we    = 1'b1;
                mem_wr.waddr = r_j;
                mem_wr.wdata = r_val_a;
            end
            irp_pkg::S_EMIT: begin
                out_load = slot_free;
                if (is_one && !r_j[0]) begin
                    out_card = r_val_a;
                end
            end
            irp_pkg::S_EMIT_LAST: begin
                out_load     = slot_free;
                out_card     = r_j[0] ? r_val_a : r_val_b;
                out_pos      = '0;
                out_last     = 1'b1;
                mem_wr.clear = slot_free;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= irp_pkg::S_IDLE;
            r_deck_size <= irp_pkg::RESET_DECK_SIZE;
            r_top       <= irp_pkg::top_of(irp_pkg::RESET_DECK_SIZE);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_acc) begin
                r_deck_size <= i_cfg.deck_size;
                r_top       <= irp_pkg::top_of(i_cfg.deck_size);
            end else if (r_state == irp_pkg::S_EMIT && slot_free && !is_one) begin
                r_top <= r_top - irp_pkg::CARD_W'(1);
            end else if (r_state == irp_pkg::S_EMIT_LAST && slot_free) begin
                r_top <= irp_pkg::top_of(r_deck_size);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_card.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: swap index, read values, result
    always_ff @(posedge i_clk) begin
        if (r_state == irp_pkg::S_DIV && rem_done) begin
            r_j <= rem;
        end
        if (r_state == irp_pkg::S_SWAP_I) begin
            r_val_a <= rdata_a;
            r_val_b <= rdata_b;
        end
        if (out_load) begin
            r_out_card <= out_card;
            r_out_pos  <= out_pos;
            r_out_last <= out_last;
        end
    end

    assign i_word.ready      = word_ready;
    assign i_cfg.ready       = cfg_ready;
    assign o_card.valid      = r_out_valid;
    assign o_card.card_value = r_out_card;
    assign o_card.position   = r_out_pos;
    assign o_card.last       = r_out_last;

    // The top position stays inside the deck and never reaches zero
    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top != '0 && r_top <= irp_pkg::top_of(r_deck_size))
        else $error("top position out of range");

    // The swap index is below the divisor
    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == irp_pkg::S_READ |-> r_j <= r_top)
        else $error("swap index beyond top position");

    // A closing transaction always carries position zero
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_pos == '0)
        else $error("last result not at position zero");

    // The remainder unit finishes only while the sequencer waits on it
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_done |-> r_state == irp_pkg::S_DIV)
        else $error("remainder finished outside divide state");

endmodule

@@ design/irp_rem_unit.sv @@
// Restoring remainder unit: one dividend bit per cycle.
// Depends on irp_pkg for widths.
module irp_rem_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [irp_pkg::WORD_W-1:0]   i_dividend,
    input  logic [irp_pkg::DVS_W-1:0]    i_divisor,
    output logic                         o_done,
    output logic [irp_pkg::CARD_W-1:0]   o_rem
);

    logic                         r_busy;
    logic                         r_done;
    logic [irp_pkg::CNT_W-1:0]    r_cnt;
    logic [irp_pkg::WORD_W-1:0]   r_dvd;
    logic [irp_pkg::DVS_W-1:0]    r_dvs;
    logic [irp_pkg::CARD_W-1:0]   r_rem;
    logic [irp_pkg::DVS_W-1:0]    trial;
    logic [irp_pkg::CARD_W-1:0]   n_rem;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        trial = {r_rem, r_dvd[irp_pkg::WORD_W-1]};
        if (trial >= r_dvs) begin
            n_rem = irp_pkg::CARD_W'(trial - r_dvs);
        end else begin
            n_rem = trial[irp_pkg::CARD_W-1:0];
        end
    end

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= irp_pkg::CNT_W'(irp_pkg::WORD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - irp_pkg::CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[irp_pkg::WORD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ design/irp_deck_mem.sv @@
// Deck store: one write port, two registered read ports, per-entry valid bits.
// An entry not written since the last clear reads as its own index. Depends on irp_pkg.
module irp_deck_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  irp_pkg::t_mem_wr             i_wr,
    input  logic [irp_pkg::CARD_W-1:0]   i_raddr_a,
    input  logic [irp_pkg::CARD_W-1:0]   i_raddr_b,
    output logic [irp_pkg::CARD_W-1:0]   o_rdata_a,
    output logic [irp_pkg::CARD_W-1:0]   o_rdata_b
);

    logic [irp_pkg::CARD_W-1:0]     mem [irp_pkg::MAX_CARDS];
    logic [irp_pkg::MAX_CARDS-1:0]  r_vld;
    logic [irp_pkg::CARD_W-1:0]     r_mem_a;
    logic [irp_pkg::CARD_W-1:0]     r_mem_b;
    logic [irp_pkg::CARD_W-1:0]     r_addr_a;
    logic [irp_pkg::CARD_W-1:0]     r_addr_b;
    logic                           r_vld_a;
    logic                           r_vld_b;

    // Valid bits: drop all on clear, mark on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr.clear) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.waddr] <= 1'b1;
        end
    end

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.waddr] <= i_wr.wdata;
        end
    end

    // Registered reads
    always_ff @(posedge i_clk) begin
        r_mem_a  <= mem[i_raddr_a];
        r_mem_b  <= mem[i_raddr_b];
        r_addr_a <= i_raddr_a;
        r_addr_b <= i_raddr_b;
        r_vld_a  <= r_vld[i_raddr_a];
        r_vld_b  <= r_vld[i_raddr_b];
    end

    assign o_rdata_a = r_vld_a ? r_mem_a : r_addr_a;
    assign o_rdata_b = r_vld_b ? r_mem_b : r_addr_b;

endmodule
